// ----- hw/rtl/multi_pattern_byte_matcher_macros.svh -----
// Assertion macros used by the matcher datapath.
`ifndef MULTI_PATTERN_BYTE_MATCHER_MACROS_SVH
`define MULTI_PATTERN_BYTE_MATCHER_MACROS_SVH
`ifndef SYNTHESIS
`define MPBM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mpbm assertion failed");
`define MPBM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mpbm assertion failed");
`else
`define MPBM_ASSERT_IMP(label, ante, cons)
`define MPBM_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/mpbm_pkg.sv -----
// Types and constants shared by the matcher controller, datapath and top level.
package mpbm_pkg;

    localparam int MAX_NODES    = 65536;
    localparam int NODE_W       = 16;
    localparam int NODE_CNT_W   = 17;
    localparam int EDGE_SLOTS   = 131072;
    localparam int SLOT_W       = 17;
    localparam int MAX_PATTERNS = 2048;
    localparam int PAT_W        = 12;
    localparam int BYTE_W       = 8;
    localparam int KEY_W        = NODE_W + BYTE_W;
    localparam int EDGE_W       = 1 + KEY_W + NODE_W;
    localparam int LEN_W        = 16;
    localparam int BUDGET_W     = 16;
    localparam int POS_W        = 31;
    localparam int EARLY_W      = 32;
    localparam int CFG_DATA_W   = 16;

    localparam logic [31:0] HASH_FULL = 32'h9E3779B1;

    localparam logic CFG_PATTERN_LIMIT = 1'b0;
    localparam logic CFG_BYTE_BUDGET   = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_TOO_MANY = 3'd1,
        STAT_BUDGET   = 3'd2,
        STAT_BAD_NODE = 3'd3,
        STAT_PHASE    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_SCAN   = 2'd3
    } action_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_SWEEP, OP_OUT_ERR, OP_OUT_ZERO, OP_KEY_ADD, OP_HASH,
        OP_EREAD, OP_ECHECK, OP_FREAD_KEY, OP_FLOAD, OP_DREAD_ADD, OP_ADD_FIN,
        OP_B_INIT, OP_KEY_B, OP_TREAD_F, OP_TREAD_C, OP_TSET, OP_ENQ, OP_NEXTB,
        OP_DEQ, OP_DEQW, OP_BUILT_OUT, OP_SCAN_START, OP_STREAD, OP_SCAN_FIN
    } mpbm_op_t;

    typedef enum logic [4:0] {
        S_RST_CLR, S_IDLE, S_DECODE, S_CLR, S_ERR, S_DONE,
        S_PR_HASH, S_PR_READ, S_PR_CHECK, S_AD_FREAD, S_AD_FLOAD,
        S_A_DREAD, S_A_FIN,
        S_B_INIT, S_B_PROBE, S_B_FPREAD, S_B_ADVSTART, S_B_TREADF, S_B_TREADC,
        S_B_TSET, S_B_ENQ, S_B_NEXTB, S_B_DEQ, S_B_DEQW, S_B_BUILT,
        S_SC_START, S_SC_TREAD, S_SC_FIN
    } mpbm_state_t;

    typedef enum logic [1:0] {
        PC_ADD, PC_BENUM, PC_ADV
    } probe_ctx_t;

    typedef enum logic {
        AC_SCAN, AC_BUILD
    } adv_ctx_t;

    typedef struct packed {
        mpbm_op_t op;
        status_t  err;
        logic     adv;
    } mpbm_cmd_t;

    typedef struct packed {
        logic    out_free;
        logic    built;
        logic    insert_root;
        logic    pat_full;
        logic    budget_full;
        logic    node_full;
        logic    st_invalid;
        logic    e_valid;
        logic    e_match;
        logic    key_root;
        logic    parent_root;
        logic    b_last;
        logic    queue_nonempty;
        logic    sweep_done;
        action_t act;
        logic    chunk_start;
    } mpbm_stat_t;

endpackage

// ----- hw/rtl/mpbm_ctrl.sv -----
// Controller state machine that sequences clear, insert, build and scan requests.
module mpbm_ctrl
    import mpbm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  mpbm_stat_t stat,
    output mpbm_cmd_t  cmd
);

    mpbm_state_t state_reg, state_next;
    probe_ctx_t  probe_ctx_reg, probe_ctx_next;
    adv_ctx_t    adv_ctx_reg, adv_ctx_next;
    status_t     err_reg, err_next;
    logic        hit;

    assign hit = stat.e_valid && stat.e_match;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_RST_CLR;
            probe_ctx_reg <= PC_ADD;
            adv_ctx_reg   <= AC_SCAN;
            err_reg       <= STAT_OK;
        end else begin
            state_reg     <= state_next;
            probe_ctx_reg <= probe_ctx_next;
            adv_ctx_reg   <= adv_ctx_next;
            err_reg       <= err_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        probe_ctx_next = probe_ctx_reg;
        adv_ctx_next   = adv_ctx_reg;
        err_next       = err_reg;
        unique case (state_reg)
            S_RST_CLR: begin
                if (stat.sweep_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) state_next = S_DECODE;
            end
            S_DECODE: begin
                unique case (stat.act)
                    ACT_CLEAR: state_next = S_CLR;
                    ACT_ADD: begin
                        if (stat.built) begin
                            err_next   = STAT_PHASE;
                            state_next = S_ERR;
                        end else if (stat.insert_root && stat.pat_full) begin
                            err_next   = STAT_TOO_MANY;
                            state_next = S_ERR;
                        end else if (stat.budget_full) begin
                            err_next   = STAT_BUDGET;
                            state_next = S_ERR;
                        end else begin
                            probe_ctx_next = PC_ADD;
                            state_next     = S_PR_HASH;
                        end
                    end
                    ACT_FINISH: begin
                        if (stat.built || !stat.insert_root) begin
                            err_next   = STAT_PHASE;
                            state_next = S_ERR;
                        end else begin
                            state_next = S_B_INIT;
                        end
                    end
                    ACT_SCAN: begin
                        if (!stat.built) begin
                            err_next   = STAT_PHASE;
                            state_next = S_ERR;
                        end else if (stat.chunk_start && stat.st_invalid) begin
                            err_next   = STAT_BAD_NODE;
                            state_next = S_ERR;
                        end else begin
                            state_next = S_SC_START;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_CLR: begin
                if (stat.sweep_done) state_next = S_DONE;
            end
            S_ERR, S_DONE, S_A_FIN, S_B_BUILT, S_SC_FIN: begin
                if (stat.out_free) state_next = S_IDLE;
            end
            S_PR_HASH: state_next = S_PR_READ;
            S_PR_READ: state_next = S_PR_CHECK;
            S_PR_CHECK: begin
                if (stat.e_valid && !stat.e_match) begin
                    state_next = S_PR_READ;
                end else begin
                    unique case (probe_ctx_reg)
                        PC_ADD: begin
                            if (!hit && stat.node_full) begin
                                err_next   = STAT_BUDGET;
                                state_next = S_ERR;
                            end else begin
                                state_next = S_A_DREAD;
                            end
                        end
                        PC_BENUM: begin
                            if (!hit) state_next = S_B_NEXTB;
                            else if (stat.parent_root) state_next = S_B_ENQ;
                            else state_next = S_B_FPREAD;
                        end
                        PC_ADV: begin
                            if (hit || stat.key_root) begin
                                state_next = (adv_ctx_reg == AC_SCAN) ? S_SC_TREAD
                                                                      : S_B_TREADF;
                            end else begin
                                state_next = S_AD_FREAD;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_AD_FREAD: state_next = S_AD_FLOAD;
            S_AD_FLOAD: state_next = S_PR_HASH;
            S_A_DREAD: state_next = S_A_FIN;
            S_B_INIT: state_next = S_B_PROBE;
            S_B_PROBE: begin
                probe_ctx_next = PC_BENUM;
                state_next     = S_PR_HASH;
            end
            S_B_FPREAD: state_next = S_B_ADVSTART;
            S_B_ADVSTART: begin
                probe_ctx_next = PC_ADV;
                adv_ctx_next   = AC_BUILD;
                state_next     = S_PR_HASH;
            end
            S_B_TREADF: state_next = S_B_TREADC;
            S_B_TREADC: state_next = S_B_TSET;
            S_B_TSET: state_next = S_B_ENQ;
            S_B_ENQ: state_next = S_B_NEXTB;
            S_B_NEXTB: state_next = stat.b_last ? S_B_DEQ : S_B_PROBE;
            S_B_DEQ: state_next = stat.queue_nonempty ? S_B_DEQW : S_B_BUILT;
            S_B_DEQW: state_next = S_B_PROBE;
            S_SC_START: begin
                probe_ctx_next = PC_ADV;
                adv_ctx_next   = AC_SCAN;
                state_next     = S_PR_HASH;
            end
            S_SC_TREAD: state_next = S_SC_FIN;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == S_IDLE);
        cmd.op  = OP_NONE;
        cmd.err = err_reg;
        cmd.adv = (probe_ctx_reg == PC_ADV);
        unique case (state_reg)
            S_IDLE:       if (s_valid) cmd.op = OP_LATCH;
            S_RST_CLR,
            S_CLR:        cmd.op = OP_SWEEP;
            S_DECODE:     if (stat.act == ACT_ADD) cmd.op = OP_KEY_ADD;
            S_ERR:        if (stat.out_free) cmd.op = OP_OUT_ERR;
            S_DONE:       if (stat.out_free) cmd.op = OP_OUT_ZERO;
            S_PR_HASH:    cmd.op = OP_HASH;
            S_PR_READ:    cmd.op = OP_EREAD;
            S_PR_CHECK:   cmd.op = OP_ECHECK;
            S_AD_FREAD:   cmd.op = OP_FREAD_KEY;
            S_AD_FLOAD:   cmd.op = OP_FLOAD;
            S_A_DREAD:    cmd.op = OP_DREAD_ADD;
            S_A_FIN:      if (stat.out_free) cmd.op = OP_ADD_FIN;
            S_B_INIT:     cmd.op = OP_B_INIT;
            S_B_PROBE:    cmd.op = OP_KEY_B;
            S_B_FPREAD:   cmd.op = OP_FREAD_KEY;
            S_B_ADVSTART: cmd.op = OP_FLOAD;
            S_B_TREADF:   cmd.op = OP_TREAD_F;
            S_B_TREADC:   cmd.op = OP_TREAD_C;
            S_B_TSET:     cmd.op = OP_TSET;
            S_B_ENQ:      cmd.op = OP_ENQ;
            S_B_NEXTB:    cmd.op = OP_NEXTB;
            S_B_DEQ:      if (stat.queue_nonempty) cmd.op = OP_DEQ;
            S_B_DEQW:     cmd.op = OP_DEQW;
            S_B_BUILT:    if (stat.out_free) cmd.op = OP_BUILT_OUT;
            S_SC_START:   cmd.op = OP_SCAN_START;
            S_SC_TREAD:   cmd.op = OP_STREAD;
            S_SC_FIN:     if (stat.out_free) cmd.op = OP_SCAN_FIN;
            default:      cmd.op = OP_NONE;
        endcase
    end

endmodule

// ----- hw/rtl/mpbm_dp.sv -----
// Datapath: trie tables, failure links, breadth-first queue, scan state and result register.
`include "multi_pattern_byte_matcher_macros.svh"
module mpbm_dp
    import mpbm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mpbm_cmd_t              cmd,
    output mpbm_stat_t             stat,
    input  logic [1:0]             in_action,
    input  logic [BYTE_W-1:0]      in_data_byte,
    input  logic                   in_last_byte,
    input  logic                   in_chunk_start,
    input  logic [NODE_W-1:0]      in_start_state,
    input  logic                   cfg_wr_en,
    input  logic                   cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output logic                   m_valid,
    input  logic                   m_ready,
    output status_t                out_status,
    output logic [NODE_W-1:0]      out_node_now,
    output logic [LEN_W-1:0]       out_node_depth,
    output logic [LEN_W-1:0]       out_match_length,
    output logic                   out_found_any,
    output logic signed [EARLY_W-1:0] out_earliest_start,
    output logic                   out_chunk_done
);

    localparam logic [SLOT_W-1:0]     HASH_MULT = HASH_FULL[SLOT_W-1:0];
    localparam logic [PAT_W-1:0]      PAT_MAX   = PAT_W'(MAX_PATTERNS);
    localparam logic [NODE_CNT_W-1:0] NODE_MAX  = NODE_CNT_W'(MAX_NODES);

    // Tables. Edge entries hold valid, key (node then byte) and child node.
    logic [EDGE_W-1:0] edge_mem  [EDGE_SLOTS];
    logic [NODE_W-1:0] fail_mem  [MAX_NODES];
    logic [LEN_W-1:0]  depth_mem [MAX_NODES];
    logic [LEN_W-1:0]  term_mem  [MAX_NODES];
    logic [NODE_W-1:0] queue_mem [MAX_NODES];

    logic [EDGE_W-1:0] edge_rd_reg;
    logic [NODE_W-1:0] fail_rd_reg;
    logic [LEN_W-1:0]  depth_rd_reg;
    logic [LEN_W-1:0]  term_rd_reg;
    logic [NODE_W-1:0] queue_rd_reg;

    // Automaton state.
    logic [PAT_W-1:0]      limit_reg;
    logic [BUDGET_W-1:0]   budget_reg;
    logic [NODE_CNT_W-1:0] node_count_reg;
    logic [BUDGET_W-1:0]   bytes_used_reg;
    logic [PAT_W-1:0]      pat_used_reg;
    logic [NODE_W-1:0]     insert_node_reg;
    logic                  built_reg;
    logic [NODE_W-1:0]     scan_node_reg;
    logic [POS_W-1:0]      pos_reg;
    logic                  found_reg;
    logic signed [EARLY_W-1:0] earliest_reg;
    logic [NODE_CNT_W-1:0] head_reg;
    logic [NODE_CNT_W-1:0] tail_reg;
    logic [SLOT_W-1:0]     clr_reg;
    logic                  m_valid_reg;

    // Working registers.
    action_t           act_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic              cs_reg;
    logic [NODE_W-1:0] st_reg;
    logic [NODE_W-1:0] key_node_reg;
    logic [BYTE_W-1:0] key_byte_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              hit_reg;
    logic [NODE_W-1:0] child_reg;
    logic [NODE_W-1:0] f_reg;
    logic [LEN_W-1:0]  tf_reg;
    logic [NODE_W-1:0] parent_reg;
    logic              parent_root_reg;
    logic [BYTE_W-1:0] b_reg;

    // Result register.
    status_t                   res_status_reg;
    logic [NODE_W-1:0]         res_node_reg;
    logic [LEN_W-1:0]          res_depth_reg;
    logic [LEN_W-1:0]          res_mlen_reg;
    logic                      res_found_reg;
    logic signed [EARLY_W-1:0] res_early_reg;
    logic                      res_done_reg;

    logic [PAT_W-1:0]          pat_limit_eff;
    logic                      out_free;
    logic                      out_load;
    logic                      e_valid;
    logic                      e_match;
    logic [NODE_W-1:0]         e_child;
    logic [NODE_W-1:0]         add_next;
    logic [LEN_W-1:0]          add_depth;
    logic [LEN_W-1:0]          term_max;
    logic signed [EARLY_W:0]   scan_start;
    logic                      scan_hit;
    logic                      found_n;
    logic signed [EARLY_W-1:0] earliest_n;

    logic                  edge_we;
    logic [SLOT_W-1:0]     edge_waddr;
    logic [EDGE_W-1:0]     edge_wdata;
    logic                  fail_we;
    logic [NODE_W-1:0]     fail_waddr;
    logic [NODE_W-1:0]     fail_wdata;
    logic                  depth_we;
    logic [NODE_W-1:0]     depth_waddr;
    logic [LEN_W-1:0]      depth_wdata;
    logic                  term_we;
    logic [NODE_W-1:0]     term_waddr;
    logic [LEN_W-1:0]      term_wdata;
    logic                  queue_we;
    logic                  depth_re;
    logic [NODE_W-1:0]     depth_raddr;
    logic                  term_re;
    logic [NODE_W-1:0]     term_raddr;

    function automatic logic [SLOT_W-1:0] edge_hash(input logic [NODE_W-1:0] node,
                                                    input logic [BYTE_W-1:0] b);
        logic [KEY_W-1:0]    key;
        logic [2*SLOT_W-1:0] prod;
        key  = {node, b};
        prod = key[SLOT_W-1:0] * HASH_MULT;
        return prod[SLOT_W-1:0];
    endfunction

    assign pat_limit_eff = (limit_reg > PAT_MAX) ? PAT_MAX : limit_reg;
    assign out_free      = !m_valid_reg || m_ready;
    assign out_load      = (cmd.op == OP_OUT_ERR) || (cmd.op == OP_OUT_ZERO) ||
                           (cmd.op == OP_ADD_FIN) || (cmd.op == OP_BUILT_OUT) ||
                           (cmd.op == OP_SCAN_FIN);
    assign e_valid       = edge_rd_reg[EDGE_W-1];
    assign e_match       = (edge_rd_reg[EDGE_W-2:NODE_W] == {key_node_reg, key_byte_reg});
    assign e_child       = edge_rd_reg[NODE_W-1:0];
    assign add_next      = hit_reg ? child_reg : node_count_reg[NODE_W-1:0];
    assign add_depth     = hit_reg ? depth_rd_reg : depth_rd_reg + LEN_W'(1);
    assign term_max      = (tf_reg > term_rd_reg) ? tf_reg : term_rd_reg;

    // Match start relative to the chunk: position plus one minus the match length.
    assign scan_start = $signed({2'b00, pos_reg}) + (EARLY_W+1)'(1)
                        - $signed({{(EARLY_W+1-LEN_W){1'b0}}, term_rd_reg});
    assign scan_hit   = (term_rd_reg != '0);
    assign found_n    = found_reg || scan_hit;
    always_comb begin
        earliest_n = earliest_reg;
        if (scan_hit && (!found_reg || scan_start < $signed({earliest_reg[EARLY_W-1],
                                                             earliest_reg}))) begin
            earliest_n = scan_start[EARLY_W-1:0];
        end
    end

    always_comb begin
        stat.out_free       = out_free;
        stat.built          = built_reg;
        stat.insert_root    = (insert_node_reg == '0);
        stat.pat_full       = (pat_used_reg >= pat_limit_eff);
        stat.budget_full    = (bytes_used_reg >= budget_reg);
        stat.node_full      = (node_count_reg >= NODE_MAX);
        stat.st_invalid     = ({1'b0, st_reg} >= node_count_reg);
        stat.e_valid        = e_valid;
        stat.e_match        = e_match;
        stat.key_root       = (key_node_reg == '0);
        stat.parent_root    = parent_root_reg;
        stat.b_last         = (b_reg == '1);
        stat.queue_nonempty = (head_reg < tail_reg);
        stat.sweep_done     = (clr_reg == '1);
        stat.act            = act_reg;
        stat.chunk_start    = cs_reg;
    end

    // Write and read port selection for the tables.
    always_comb begin
        edge_we     = 1'b0;
        edge_waddr  = slot_reg;
        edge_wdata  = {1'b1, key_node_reg, key_byte_reg, add_next};
        fail_we     = 1'b0;
        fail_waddr  = add_next;
        fail_wdata  = '0;
        depth_we    = 1'b0;
        depth_waddr = add_next;
        depth_wdata = add_depth;
        term_we     = 1'b0;
        term_waddr  = add_next;
        term_wdata  = last_reg ? add_depth : '0;
        queue_we    = 1'b0;
        depth_re    = 1'b0;
        depth_raddr = f_reg;
        term_re     = 1'b0;
        term_raddr  = f_reg;
        case (cmd.op)
            OP_SWEEP: begin
                edge_we     = 1'b1;
                edge_waddr  = clr_reg;
                edge_wdata  = '0;
                fail_we     = 1'b1;
                fail_waddr  = '0;
                depth_we    = 1'b1;
                depth_waddr = '0;
                depth_wdata = '0;
                term_we     = 1'b1;
                term_waddr  = '0;
                term_wdata  = '0;
            end
            OP_ADD_FIN: begin
                edge_we  = !hit_reg;
                fail_we  = !hit_reg;
                depth_we = !hit_reg;
                term_we  = !hit_reg || last_reg;
            end
            OP_TSET: begin
                fail_we    = 1'b1;
                fail_waddr = child_reg;
                fail_wdata = f_reg;
                term_we    = 1'b1;
                term_waddr = child_reg;
                term_wdata = term_max;
            end
            OP_ENQ: queue_we = (tail_reg < NODE_MAX);
            OP_DREAD_ADD: begin
                depth_re    = 1'b1;
                depth_raddr = hit_reg ? child_reg : insert_node_reg;
            end
            OP_TREAD_F: term_re = 1'b1;
            OP_TREAD_C: begin
                term_re    = 1'b1;
                term_raddr = child_reg;
            end
            OP_STREAD: begin
                term_re  = 1'b1;
                depth_re = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
        if (cmd.op == OP_EREAD) edge_rd_reg <= edge_mem[slot_reg];
    end

    always_ff @(posedge aclk) begin
        if (fail_we) fail_mem[fail_waddr] <= fail_wdata;
        if (cmd.op == OP_FREAD_KEY) fail_rd_reg <= fail_mem[key_node_reg];
    end

    always_ff @(posedge aclk) begin
        if (depth_we) depth_mem[depth_waddr] <= depth_wdata;
        if (depth_re) depth_rd_reg <= depth_mem[depth_raddr];
    end

    always_ff @(posedge aclk) begin
        if (term_we) term_mem[term_waddr] <= term_wdata;
        if (term_re) term_rd_reg <= term_mem[term_raddr];
    end

    always_ff @(posedge aclk) begin
        if (queue_we) queue_mem[tail_reg[NODE_W-1:0]] <= child_reg;
        if (cmd.op == OP_DEQ) queue_rd_reg <= queue_mem[head_reg[NODE_W-1:0]];
    end

    // Automaton state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg       <= PAT_MAX;
            budget_reg      <= '1;
            node_count_reg  <= NODE_CNT_W'(1);
            bytes_used_reg  <= '0;
            pat_used_reg    <= '0;
            insert_node_reg <= '0;
            built_reg       <= 1'b0;
            scan_node_reg   <= '0;
            pos_reg         <= '0;
            found_reg       <= 1'b0;
            earliest_reg    <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            clr_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_PATTERN_LIMIT) limit_reg <= cfg_wdata[PAT_W-1:0];
                else budget_reg <= cfg_wdata[BUDGET_W-1:0];
            end
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (cmd.op)
                OP_SWEEP: begin
                    clr_reg         <= clr_reg + SLOT_W'(1);
                    node_count_reg  <= NODE_CNT_W'(1);
                    bytes_used_reg  <= '0;
                    pat_used_reg    <= '0;
                    insert_node_reg <= '0;
                    built_reg       <= 1'b0;
                    scan_node_reg   <= '0;
                    pos_reg         <= '0;
                    found_reg       <= 1'b0;
                    earliest_reg    <= '0;
                end
                OP_ADD_FIN: begin
                    if (insert_node_reg == '0) pat_used_reg <= pat_used_reg + PAT_W'(1);
                    bytes_used_reg <= bytes_used_reg + BUDGET_W'(1);
                    if (!hit_reg) node_count_reg <= node_count_reg + NODE_CNT_W'(1);
                    insert_node_reg <= last_reg ? '0 : add_next;
                end
                OP_B_INIT: begin
                    head_reg <= '0;
                    tail_reg <= '0;
                end
                OP_ENQ: if (tail_reg < NODE_MAX) tail_reg <= tail_reg + NODE_CNT_W'(1);
                OP_DEQ: head_reg <= head_reg + NODE_CNT_W'(1);
                OP_BUILT_OUT: built_reg <= 1'b1;
                OP_SCAN_START: begin
                    if (cs_reg) begin
                        scan_node_reg <= st_reg;
                        pos_reg       <= '0;
                        found_reg     <= 1'b0;
                        earliest_reg  <= '0;
                    end
                end
                OP_SCAN_FIN: begin
                    scan_node_reg <= f_reg;
                    if (last_reg) begin
                        pos_reg      <= '0;
                        found_reg    <= 1'b0;
                        earliest_reg <= '0;
                    end else begin
                        if (pos_reg != '1) pos_reg <= pos_reg + POS_W'(1);
                        found_reg    <= found_n;
                        earliest_reg <= earliest_n;
                    end
                end
                default: ;
            endcase
        end
    end

    // Working registers and the result register.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LATCH: begin
                act_reg  <= action_t'(in_action);
                byte_reg <= in_data_byte;
                last_reg <= in_last_byte;
                cs_reg   <= in_chunk_start;
                st_reg   <= in_start_state;
            end
            OP_KEY_ADD: begin
                key_node_reg <= insert_node_reg;
                key_byte_reg <= byte_reg;
            end
            OP_SCAN_START: begin
                key_node_reg <= cs_reg ? st_reg : scan_node_reg;
                key_byte_reg <= byte_reg;
            end
            OP_HASH: slot_reg <= edge_hash(key_node_reg, key_byte_reg);
            OP_ECHECK: begin
                hit_reg <= e_valid && e_match;
                if (e_valid && !e_match) slot_reg <= slot_reg + SLOT_W'(1);
                if (e_valid && e_match) begin
                    if (cmd.adv) f_reg <= e_child;
                    else child_reg <= e_child;
                end else if (!e_valid && cmd.adv) begin
                    f_reg <= '0;
                end
            end
            OP_FLOAD: key_node_reg <= fail_rd_reg;
            OP_B_INIT: begin
                parent_reg      <= '0;
                parent_root_reg <= 1'b1;
                b_reg           <= '0;
            end
            OP_KEY_B: begin
                key_node_reg <= parent_reg;
                key_byte_reg <= b_reg;
            end
            OP_TREAD_C: tf_reg <= term_rd_reg;
            OP_NEXTB: b_reg <= b_reg + BYTE_W'(1);
            OP_DEQW: begin
                parent_reg      <= queue_rd_reg;
                parent_root_reg <= 1'b0;
                b_reg           <= '0;
            end
            OP_OUT_ERR, OP_OUT_ZERO, OP_BUILT_OUT: begin
                res_status_reg <= (cmd.op == OP_OUT_ERR) ? cmd.err : STAT_OK;
                res_node_reg   <= '0;
                res_depth_reg  <= '0;
                res_mlen_reg   <= '0;
                res_found_reg  <= 1'b0;
                res_early_reg  <= '0;
                res_done_reg   <= 1'b0;
            end
            OP_ADD_FIN: begin
                res_status_reg <= STAT_OK;
                res_node_reg   <= add_next;
                res_depth_reg  <= add_depth;
                res_mlen_reg   <= '0;
                res_found_reg  <= 1'b0;
                res_early_reg  <= '0;
                res_done_reg   <= 1'b0;
            end
            OP_SCAN_FIN: begin
                res_status_reg <= STAT_OK;
                res_node_reg   <= f_reg;
                res_depth_reg  <= depth_rd_reg;
                res_mlen_reg   <= term_rd_reg;
                res_found_reg  <= found_n;
                res_early_reg  <= (last_reg && found_n) ? earliest_n : '0;
                res_done_reg   <= last_reg;
            end
            default: ;
        endcase
    end

    assign m_valid            = m_valid_reg;
    assign out_status         = res_status_reg;
    assign out_node_now       = res_node_reg;
    assign out_node_depth     = res_depth_reg;
    assign out_match_length   = res_mlen_reg;
    assign out_found_any      = res_found_reg;
    assign out_earliest_start = res_early_reg;
    assign out_chunk_done     = res_done_reg;

    `MPBM_ASSERT_IMP(a_result_slot_free, out_load, out_free)
    `MPBM_ASSERT_IMP(a_deq_nonempty, cmd.op == OP_DEQ, head_reg < tail_reg)
    `MPBM_ASSERT_IMP(a_new_node_room, cmd.op == OP_ADD_FIN && !hit_reg, node_count_reg < NODE_MAX)
    `MPBM_ASSERT_NXT(a_enq_advances, cmd.op == OP_ENQ && tail_reg < NODE_MAX, tail_reg == $past(tail_reg) + NODE_CNT_W'(1))

endmodule

// ----- hw/rtl/multi_pattern_byte_matcher.sv -----
// Scan request: result valid after the edge probe, plus an extra probe per collision and a lookup per failure link.
// Add request: result valid after the edge probe and depth read, plus an extra probe per collision.
// Finish request: 256 byte probes for each trie node, plus link walks.
// Clear request and reset: a sweep over all 131072 slots of the edge table with no request accepted.
// One request in flight at a time; the next can be accepted once the result is registered, even before it is taken.
// Reset is synchronous, active low; it restores both registers and empties the edge table.
module multi_pattern_byte_matcher
    import mpbm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // data_byte[7:0], start_state[23:8]
    input  logic        s_axis_tlast,
    input  logic [2:0]  s_axis_tuser,   // action[1:0], chunk_start[2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // node_now[15:0], node_depth[31:16],
                                        // match_length[47:32], found_any[48],
                                        // earliest_start[80:49], zero fill[87:81]
    output logic        m_axis_tlast,
    output logic [2:0]  m_axis_tuser,   // status[2:0]
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);

    mpbm_cmd_t                 cmd;
    mpbm_stat_t                stat;
    status_t                   res_status;
    logic [NODE_W-1:0]         res_node;
    logic [LEN_W-1:0]          res_depth;
    logic [LEN_W-1:0]          res_mlen;
    logic                      res_found;
    logic signed [EARLY_W-1:0] res_early;

    mpbm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mpbm_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .in_action          (s_axis_tuser[1:0]),
        .in_data_byte       (s_axis_tdata[7:0]),
        .in_last_byte       (s_axis_tlast),
        .in_chunk_start     (s_axis_tuser[2]),
        .in_start_state     (s_axis_tdata[23:8]),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .m_valid            (m_axis_tvalid),
        .m_ready            (m_axis_tready),
        .out_status         (res_status),
        .out_node_now       (res_node),
        .out_node_depth     (res_depth),
        .out_match_length   (res_mlen),
        .out_found_any      (res_found),
        .out_earliest_start (res_early),
        .out_chunk_done     (m_axis_tlast)
    );

    assign m_axis_tuser = res_status;
    assign m_axis_tdata = {7'b0, res_early, res_found, res_mlen, res_depth, res_node};

endmodule
